FILE: sv/iols_pkg.sv
// Shared types and constants for the indexed ordered list store.
package iols_pkg;

    // Fixed field widths of the stream payloads.
    localparam int KIND_W   = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    // Packed stream widths, padded up to whole bytes.
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 144;

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATE = 3'd0,
        KIND_APPEND = 3'd1,
        KIND_INSERT = 3'd2,
        KIND_REMOVE = 3'd3,
        KIND_AMEND  = 3'd4,
        KIND_READ   = 3'd5
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_DRAIN,
        S_PLACE,
        S_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    status_we;
        t_status status;
        logic    place;
        logic    amend;
        logic    rd_issue;
        logic    walk_init;
        logic    walk_step;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    cnt_one;
        logic    out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_kind kind;
        logic  empty;
        logic  pos_ok;
        logic  full;
        logic  single;
        logic  at_end;
        logic  slot_last;
        logic  walk_last;
        logic  out_free;
    } t_stat;

endpackage

FILE: sv/iols_ctrl.sv
// Controller state machine for the indexed ordered list store.
module iols_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  iols_pkg::t_stat     i_stat,
    output iols_pkg::t_cmd      o_cmd
);

    iols_pkg::t_state r_state;
    iols_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iols_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            iols_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = iols_pkg::S_DECODE;
                end
            end
            iols_pkg::S_DECODE: begin
                o_cmd.status_we = 1'b1;
                o_cmd.status    = iols_pkg::ST_OK;
                n_state         = iols_pkg::S_RESULT;
                case (i_stat.kind)
                    iols_pkg::KIND_CREATE: begin
                        o_cmd.place   = 1'b1;
                        o_cmd.cnt_one = 1'b1;
                    end
                    iols_pkg::KIND_APPEND: begin
                        if (i_stat.empty) begin
                            o_cmd.status = iols_pkg::ST_EMPTY;
                        end else if (i_stat.full) begin
                            o_cmd.status = iols_pkg::ST_FULL;
                        end else begin
                            o_cmd.place   = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                        end
                    end
                    iols_pkg::KIND_INSERT: begin
                        if (i_stat.empty) begin
                            o_cmd.status = iols_pkg::ST_EMPTY;
                        end else if (!i_stat.pos_ok) begin
                            o_cmd.status = iols_pkg::ST_BADPOS;
                        end else if (i_stat.full) begin
                            o_cmd.status = iols_pkg::ST_FULL;
                        end else if (i_stat.at_end) begin
                            o_cmd.place   = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                        end else begin
                            o_cmd.walk_init = 1'b1;
                            n_state         = iols_pkg::S_WALK;
                        end
                    end
                    iols_pkg::KIND_REMOVE: begin
                        if (i_stat.empty) begin
                            o_cmd.status = iols_pkg::ST_EMPTY;
                        end else if (!i_stat.pos_ok) begin
                            o_cmd.status = iols_pkg::ST_BADPOS;
                        end else if (i_stat.single) begin
                            o_cmd.status = iols_pkg::ST_EMPTY;
                        end else if (i_stat.slot_last) begin
                            o_cmd.cnt_dec = 1'b1;
                        end else begin
                            o_cmd.walk_init = 1'b1;
                            n_state         = iols_pkg::S_WALK;
                        end
                    end
                    iols_pkg::KIND_AMEND: begin
                        if (i_stat.empty) begin
                            o_cmd.status = iols_pkg::ST_EMPTY;
                        end else if (!i_stat.pos_ok) begin
                            o_cmd.status = iols_pkg::ST_BADPOS;
                        end else begin
                            o_cmd.amend = 1'b1;
                        end
                    end
                    iols_pkg::KIND_READ: begin
                        if (i_stat.empty) begin
                            o_cmd.status = iols_pkg::ST_EMPTY;
                        end else if (!i_stat.pos_ok) begin
                            o_cmd.status = iols_pkg::ST_BADPOS;
                        end else begin
                            o_cmd.rd_issue = 1'b1;
                        end
                    end
                    default: begin
                        // Unused kinds leave the store alone and report success.
                        o_cmd.status = iols_pkg::ST_OK;
                    end
                endcase
            end
            iols_pkg::S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = iols_pkg::S_DRAIN;
                end
            end
            iols_pkg::S_DRAIN: begin
                // The last moved entry is written back during this cycle.
                if (i_stat.kind == iols_pkg::KIND_INSERT) begin
                    n_state = iols_pkg::S_PLACE;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = iols_pkg::S_RESULT;
                end
            end
            iols_pkg::S_PLACE: begin
                o_cmd.place   = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                n_state       = iols_pkg::S_RESULT;
            end
            iols_pkg::S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = iols_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = iols_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/iols_datapath.sv
// Datapath of the indexed ordered list store: entry memories, count, walk and result register.
module iols_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  iols_pkg::t_cmd                    i_cmd,
    output iols_pkg::t_stat                   o_stat,
    input  logic [iols_pkg::KIND_W-1:0]       i_in_kind,
    input  logic [iols_pkg::POS_W-1:0]        i_in_pos,
    input  logic [iols_pkg::DATA_W-1:0]       i_in_value,
    input  logic [iols_pkg::DATA_W-1:0]       i_in_stamp,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [iols_pkg::STATUS_W-1:0]     o_status,
    output logic [iols_pkg::LEN_W-1:0]        o_length,
    output logic [iols_pkg::DATA_W-1:0]       o_read_value,
    output logic [iols_pkg::DATA_W-1:0]       o_read_stamp
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > iols_pkg::POS_W) ? CW : iols_pkg::POS_W;

    logic [iols_pkg::DATA_W-1:0] mem_value [CAPACITY];
    logic [iols_pkg::DATA_W-1:0] mem_stamp [CAPACITY];

    iols_pkg::t_kind              r_kind;
    logic [iols_pkg::POS_W-1:0]   r_pos;
    logic [iols_pkg::DATA_W-1:0]  r_value;
    logic [iols_pkg::DATA_W-1:0]  r_stamp;
    iols_pkg::t_status            r_status;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                r_idx;
    logic                         r_wpend;
    logic [AW-1:0]                r_waddr;
    logic [iols_pkg::DATA_W-1:0]  r_rd_value;
    logic [iols_pkg::DATA_W-1:0]  r_rd_stamp;
    logic                         r_out_valid;
    iols_pkg::t_status            r_out_status;
    logic [iols_pkg::LEN_W-1:0]   r_out_len;
    logic [iols_pkg::DATA_W-1:0]  r_out_rv;
    logic [iols_pkg::DATA_W-1:0]  r_out_rs;

    logic                         pos_neg1;
    logic                         is_insert;
    logic [CMPW-1:0]              pos_ext;
    logic [CMPW-1:0]              cnt_ext;
    logic [CW-1:0]                count_m1;
    logic [CW-1:0]                slot;
    logic [CW-1:0]                place_addr;
    logic [CW-1:0]                n_idx_up;
    logic [CW-1:0]                n_idx_down;
    logic                         use_rd;

    logic                         we_v;
    logic                         we_s;
    logic [AW-1:0]                waddr;
    logic [iols_pkg::DATA_W-1:0]  wv;
    logic [iols_pkg::DATA_W-1:0]  ws;
    logic                         re;
    logic [AW-1:0]                raddr;

    assign pos_neg1   = (r_pos == {iols_pkg::POS_W{1'b1}});
    assign is_insert  = (r_kind == iols_pkg::KIND_INSERT);
    assign pos_ext    = CMPW'(r_pos);
    assign cnt_ext    = CMPW'(r_count);
    assign count_m1   = r_count - 1'b1;
    assign slot       = pos_neg1 ? count_m1 : CW'(pos_ext);
    assign n_idx_up   = r_idx + 1'b1;
    assign n_idx_down = r_idx - 1'b1;

    always_comb begin
        if (r_kind == iols_pkg::KIND_CREATE) begin
            place_addr = '0;
        end else if (r_kind == iols_pkg::KIND_APPEND || pos_neg1) begin
            place_addr = r_count;
        end else begin
            place_addr = slot;
        end
    end

    always_comb begin
        o_stat.kind      = r_kind;
        o_stat.empty     = (r_count == '0);
        o_stat.pos_ok    = (r_count != '0) &&
                           (pos_neg1 || (!r_pos[iols_pkg::POS_W-1] && (pos_ext < cnt_ext)));
        o_stat.full      = (r_count == CW'(CAPACITY));
        o_stat.single    = (r_count == CW'(1));
        o_stat.at_end    = pos_neg1;
        o_stat.slot_last = (slot == count_m1);
        o_stat.walk_last = is_insert ? (r_idx == slot) : (r_idx == count_m1);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    // One write port: a pending walk write wins; the controller never
    // issues place or amend while one is pending.
    always_comb begin
        we_v  = 1'b0;
        we_s  = 1'b0;
        waddr = r_waddr;
        wv    = r_rd_value;
        ws    = r_rd_stamp;
        if (r_wpend) begin
            we_v = 1'b1;
            we_s = 1'b1;
        end else if (i_cmd.place) begin
            we_v  = 1'b1;
            we_s  = 1'b1;
            waddr = place_addr[AW-1:0];
            wv    = r_value;
            ws    = r_stamp;
        end else if (i_cmd.amend) begin
            we_v  = 1'b1;
            waddr = slot[AW-1:0];
            wv    = r_value;
        end
    end

    assign re    = i_cmd.rd_issue || i_cmd.walk_step;
    assign raddr = i_cmd.rd_issue ? slot[AW-1:0] : r_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (we_v) begin
            mem_value[waddr] <= wv;
        end
        if (we_s) begin
            mem_stamp[waddr] <= ws;
        end
        if (re) begin
            r_rd_value <= mem_value[raddr];
            r_rd_stamp <= mem_stamp[raddr];
        end
    end

    // Item capture, walk index and status.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= iols_pkg::t_kind'(i_in_kind);
            r_pos   <= i_in_pos;
            r_value <= i_in_value;
            r_stamp <= i_in_stamp;
        end
        if (i_cmd.status_we) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.walk_init) begin
            r_idx <= is_insert ? count_m1 : (slot + 1'b1);
        end else if (i_cmd.walk_step) begin
            r_idx <= is_insert ? n_idx_down : n_idx_up;
        end
        if (i_cmd.walk_step) begin
            r_waddr <= is_insert ? n_idx_up[AW-1:0] : n_idx_down[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wpend <= 1'b0;
        end else begin
            r_wpend <= i_cmd.walk_step;
            if (i_cmd.cnt_one) begin
                r_count <= CW'(1);
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= count_m1;
            end
        end
    end

    assign use_rd = (r_kind == iols_pkg::KIND_READ) && (r_status == iols_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_len    <= iols_pkg::LEN_W'(cnt_ext);
            r_out_rv     <= use_rd ? r_rd_value : '0;
            r_out_rs     <= use_rd ? r_rd_stamp : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_length     = r_out_len;
    assign o_read_value = r_out_rv;
    assign o_read_stamp = r_out_rs;

endmodule

FILE: sv/indexed_ordered_list_store_top.sv
// Top level of the indexed ordered list store.
//
// The block keeps an ordered list of up to CAPACITY entries, each a signed
// 64-bit value with a signed 64-bit timestamp. Each transfer on the slave
// stream is one operation, chosen by s_axis_tuser: create, append, insert,
// remove, amend value or read entry. Every operation produces exactly one
// transfer on the master stream carrying a status, the length after the
// operation and, for a successful read, the entry that was read.
// Items are handled one at a time. Create, append, amend, read, an insert at
// the end, a remove of the last entry and every flagged operation go from
// decode straight to the result. Any other insert moves the entries from the
// chosen position onward up by one, one entry per cycle, then places the new
// entry; any other remove moves the entries behind it down in the same way.
// A synchronous active-low reset empties the list and drops any pending
// result; the entry memories are not cleared, since no entry at or beyond
// the length is ever read. When the receiver stalls, the result is held in
// the output register; the block still accepts the next item but waits
// before loading its result.
module indexed_ordered_list_store_top #(
    parameter int CAPACITY = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // position[6:0], value[70:7], stamp[134:71], zero padding above
    input  logic [iols_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // kind[2:0]
    input  logic [iols_pkg::KIND_W-1:0]          s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // status[1:0], length[8:2], read_value[72:9], read_stamp[136:73], zero padding above
    output logic [iols_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    iols_pkg::t_cmd                  cmd;
    iols_pkg::t_stat                 stat;
    logic [iols_pkg::STATUS_W-1:0]   out_status;
    logic [iols_pkg::LEN_W-1:0]      out_length;
    logic [iols_pkg::DATA_W-1:0]     out_value;
    logic [iols_pkg::DATA_W-1:0]     out_stamp;

    iols_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    iols_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_in_kind    (s_axis_tuser),
        .i_in_pos     (s_axis_tdata[6:0]),
        .i_in_value   (s_axis_tdata[70:7]),
        .i_in_stamp   (s_axis_tdata[134:71]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_status     (out_status),
        .o_length     (out_length),
        .o_read_value (out_value),
        .o_read_stamp (out_stamp)
    );

    assign m_axis_tdata = {7'b0, out_stamp, out_value, out_length, out_status};

endmodule

FILE: sv/iols_checker.sv
// Port-level assertions for the indexed ordered list store, bound to the top level.
module iols_checker #(
    parameter int CAPACITY = 64
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic [iols_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    input logic [iols_pkg::KIND_W-1:0]          s_axis_tuser,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [iols_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    // A held result must not change while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Reset drops any pending result.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Items are handled one at a time: the cycle after a transfer is busy.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in progress");

    // Only a successful read carries entry data.
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != iols_pkg::ST_OK)
        |-> (m_axis_tdata[72:9] == '0) && (m_axis_tdata[136:73] == '0))
        else $error("entry data on a failed operation");

    // The reported length never exceeds the capacity.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (CAPACITY > 127) || (m_axis_tdata[8:2] <= CAPACITY))
        else $error("length beyond capacity");

endmodule

bind indexed_ordered_list_store_top iols_checker #(.CAPACITY(CAPACITY)) u_iols_checker (.*);
